// ===== rtl/ordered_value_list_assert.svh =====
// assertion macros used by the ordered value list datapath
`ifndef ORDERED_VALUE_LIST_ASSERT_SVH
`define ORDERED_VALUE_LIST_ASSERT_SVH

// condition holds at every clock edge out of reset
`define OVL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ordered value list assertion failed");

// antecedent implies consequent in the same cycle
`define OVL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered value list assertion failed");

`endif

// ===== rtl/ovl_pkg.sv =====
// shared constants and command/status types of the ordered value list
package ovl_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
   localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
   localparam logic [2:0] FUNC_SEARCH    = 3'd2;
   localparam logic [2:0] FUNC_REMOVE    = 3'd3;
   localparam logic [2:0] FUNC_DUMP      = 3'd4;

   localparam logic [2:0] STAT_DONE     = 3'd0;
   localparam logic [2:0] STAT_FOUND    = 3'd1;
   localparam logic [2:0] STAT_NOTFOUND = 3'd2;
   localparam logic [2:0] STAT_EMPTY    = 3'd3;
   localparam logic [2:0] STAT_FULL     = 3'd4;

   typedef struct packed {
      logic       capture;
      logic       fwd_init;
      logic       bwd_init;
      logic       scan_run;
      logic       put;
      logic       cnt_dec;
      logic       rsp_en;
      logic [2:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic       count_zero;
      logic       count_full;
      logic       scan_done;
      logic       matched;
      logic [2:0] func;
   } dp_stat_type;

endpackage

// ===== rtl/ovl_ram.sv =====
// generic single-write, single-read ram with registered read data
module ovl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ovl_dpath.sv =====
// datapath: entry ram, count, scan pointer, match tracking and result registers
`include "ordered_value_list_assert.svh"

module ovl_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                req_func,
   input  logic signed [31:0]        req_value,
   input  ovl_pkg::dp_cmd_type       cmd,
   output ovl_pkg::dp_stat_type      stat,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic signed [31:0]        rsp_entry_value,
   output logic                      rsp_last
);

   logic [ovl_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [2:0]                 func_ff, func_in;
   logic signed [31:0]         value_ff, value_in;
   logic [ovl_pkg::IDX_W-1:0]  rd_ff, rd_in;
   logic                       rd_more_ff, rd_more_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [ovl_pkg::IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic                       matched_ff, matched_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_status_ff, rsp_status_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                            wr_en;
   logic [ovl_pkg::IDX_W-1:0]       wr_addr;
   logic [ovl_pkg::DATA_W-1:0]      wr_data;
   logic                            rd_en;
   logic [ovl_pkg::DATA_W-1:0]      rd_data;
   logic                            fwd;
   logic                            hit;
   logic                            arrive;
   logic                            dump_beat;

   ovl_ram #(
      .WIDTH (ovl_pkg::DATA_W),
      .DEPTH (ovl_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      fwd       = (func_ff != ovl_pkg::FUNC_INS_FRONT);
      arrive    = cmd.scan_run && pend_valid_ff;
      hit       = arrive && (rd_data == value_ff);
      rd_en     = cmd.scan_run && rd_more_ff;
      dump_beat = arrive && (func_ff == ovl_pkg::FUNC_DUMP);

      func_in  = func_ff;
      value_in = value_ff;
      if (cmd.capture) begin
         func_in  = req_func;
         value_in = req_value;
      end

      rd_in      = rd_ff;
      rd_more_in = rd_more_ff;
      if (cmd.fwd_init) begin
         rd_in      = '0;
         rd_more_in = (count_ff != '0);
      end else if (cmd.bwd_init) begin
         rd_in      = ovl_pkg::IDX_W'(count_ff - ovl_pkg::CNT_W'(1));
         rd_more_in = (count_ff != '0);
      end else if (rd_en) begin
         if (fwd) begin
            rd_in      = rd_ff + ovl_pkg::IDX_W'(1);
            rd_more_in = ((ovl_pkg::CNT_W'(rd_ff) + ovl_pkg::CNT_W'(1)) < count_ff);
         end else begin
            rd_in      = rd_ff - ovl_pkg::IDX_W'(1);
            rd_more_in = (rd_ff != '0);
         end
      end

      pend_valid_in = rd_en;
      pend_idx_in   = rd_ff;

      matched_in = matched_ff;
      if (cmd.fwd_init) begin
         matched_in = 1'b0;
      end else if (hit && fwd) begin
         matched_in = 1'b1;
      end

      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = (func_ff == ovl_pkg::FUNC_INS_FRONT) ? '0 : count_ff[ovl_pkg::IDX_W-1:0];
         wr_data = value_ff;
      end else if (arrive && (func_ff == ovl_pkg::FUNC_INS_FRONT)) begin
         wr_en   = 1'b1;
         wr_addr = pend_idx_ff + ovl_pkg::IDX_W'(1);
      end else if (arrive && (func_ff == ovl_pkg::FUNC_REMOVE) && matched_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_idx_ff - ovl_pkg::IDX_W'(1);
      end

      count_in = count_ff;
      if (cmd.put) begin
         count_in = count_ff + ovl_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - ovl_pkg::CNT_W'(1);
      end

      rsp_valid_in = cmd.rsp_en || dump_beat;
      if (cmd.rsp_en) begin
         rsp_status_in = cmd.rsp_status;
         rsp_data_in   = (cmd.rsp_status == ovl_pkg::STAT_FOUND) ? value_ff : '0;
         rsp_last_in   = 1'b1;
      end else begin
         rsp_status_in = ovl_pkg::STAT_DONE;
         rsp_data_in   = rd_data;
         rsp_last_in   = (ovl_pkg::CNT_W'(pend_idx_ff) == (count_ff - ovl_pkg::CNT_W'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_more_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         matched_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_more_ff    <= rd_more_in;
         pend_valid_ff <= pend_valid_in;
         matched_ff    <= matched_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      rd_ff         <= rd_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == ovl_pkg::CNT_W'(ovl_pkg::DEPTH));
   assign stat.scan_done  = !rd_more_ff && !pend_valid_ff;
   assign stat.matched    = matched_ff;
   assign stat.func       = func_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   `OVL_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= ovl_pkg::CNT_W'(ovl_pkg::DEPTH))
   `OVL_ASSERT_IMPLY(a_no_rw_clash, clock, reset, wr_en && rd_en, wr_addr != rd_ff)
   `OVL_ASSERT_IMPLY(a_capture_quiet, clock, reset, cmd.capture, !pend_valid_ff && !rd_more_ff)
   `OVL_ASSERT_IMPLY(a_put_not_full, clock, reset, cmd.put, !stat.count_full)

endmodule

// ===== rtl/ovl_ctrl.sv =====
// controller state machine: decodes requests and sequences scans and writes
module ovl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            req_func,
   input  ovl_pkg::dp_stat_type  stat,
   output logic                  busy,
   output ovl_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FWD  = 4'b0010,
      S_BWD  = 4'b0100,
      S_PUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_func) inside
                  ovl_pkg::FUNC_INS_FRONT: begin
                     if (stat.count_full) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ovl_pkg::STAT_FULL;
                     end else begin
                        cmd.capture = 1'b1;
                        if (stat.count_zero) begin
                           state_in = S_PUT;
                        end else begin
                           cmd.bwd_init = 1'b1;
                           state_in     = S_BWD;
                        end
                     end
                  end
                  ovl_pkg::FUNC_INS_BACK: begin
                     if (stat.count_full) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ovl_pkg::STAT_FULL;
                     end else begin
                        cmd.capture = 1'b1;
                        state_in    = S_PUT;
                     end
                  end
                  ovl_pkg::FUNC_SEARCH: begin
                     if (stat.count_zero) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ovl_pkg::STAT_NOTFOUND;
                     end else begin
                        cmd.capture  = 1'b1;
                        cmd.fwd_init = 1'b1;
                        state_in     = S_FWD;
                     end
                  end
                  ovl_pkg::FUNC_REMOVE, ovl_pkg::FUNC_DUMP: begin
                     if (stat.count_zero) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ovl_pkg::STAT_EMPTY;
                     end else begin
                        cmd.capture  = 1'b1;
                        cmd.fwd_init = 1'b1;
                        state_in     = S_FWD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FWD: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_IDLE;
               unique case (stat.func)
                  ovl_pkg::FUNC_SEARCH: begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = stat.matched ? ovl_pkg::STAT_FOUND
                                                   : ovl_pkg::STAT_NOTFOUND;
                  end
                  ovl_pkg::FUNC_REMOVE: begin
                     cmd.rsp_en     = 1'b1;
                     cmd.cnt_dec    = stat.matched;
                     cmd.rsp_status = stat.matched ? ovl_pkg::STAT_DONE
                                                   : ovl_pkg::STAT_NOTFOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BWD: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.put        = 1'b1;
            cmd.rsp_en     = 1'b1;
            cmd.rsp_status = ovl_pkg::STAT_DONE;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/ordered_value_list.sv =====
// top level of the ordered value list: controller plus datapath
//
//   channel   ports                                         beat when
//   request   start, req_func, req_value, busy              start && !busy
//   result    rsp_valid, rsp_status, rsp_entry_value,       rsp_valid
//             rsp_last
//
// insert back needs no walk; full-list insert, empty-list search, remove or dump answer from
// idle; an unknown func gets no result; search, remove and dump walk forward, insert front
// backward (none when empty), one entry per cycle via the single read port of the entry ram
// results appear in the cycle after the step that makes them; dump gives one per cycle
// synchronous active-high reset empties the list; the ram needs no clearing pass
// busy drops as the last result appears, after it for dump; the receiver cannot stall them

module ordered_value_list (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_value,
   output logic               busy,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);

   ovl_pkg::dp_cmd_type  cmd;
   ovl_pkg::dp_stat_type stat;

   ovl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   ovl_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last)
   );

endmodule
